// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the sorted priority queue.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mpq_pkg.sv -----
// Shared types and constants of the sorted min priority queue.
// No dependencies; imported by mpq_cell and min_priority_queue_sorted.
package mpq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int KEY_W         = 32;
  localparam int CNT_OUT_W     = 5;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
    key_t key;
  } cell_ctl_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic gt;
    key_t key;
  } cell_link_t;

endpackage

// ----- rtl/mpq_cell.sv -----
// One storage cell of the sorted chain: holds a key, compares it with the broadcast key.
// Depends on mpq_pkg.
module mpq_cell
  import mpq_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       occupied,
  input  logic       at_tail,
  input  cell_link_t from_left,
  input  key_t       from_right,
  output cell_link_t to_right
);

  key_t key_r;
  key_t key_nxt;
  logic gt;

  always_comb begin
    gt      = occupied && (key_r > ctl.key);
    key_nxt = key_r;
    if (ctl.enq && (gt || at_tail)) begin
      // left neighbor also moves up: take its key, else this is the insert slot
      key_nxt = from_left.gt ? from_left.key : ctl.key;
    end else if (ctl.deq) begin
      key_nxt = from_right;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign to_right.gt  = gt;
  assign to_right.key = key_r;

endmodule

// ----- rtl/min_priority_queue_sorted.sv -----
// Channel  Ports                       Payload
// input    in_tvalid/in_tready         tdata: value; tuser: func
// result   out_tvalid/out_tready       tdata: dequeued_key, entry_count; tuser: status
//
// One transaction per cycle while the output register can take it: every cell compares
// its key with the broadcast key and shifts or loads in the same cycle, and the result
// appears in the output register in the cycle after acceptance.
// rst_n (synchronous) empties the queue and the output register; key cells are not cleared.
// A stalled result stalls the input only while the output register is still full.
// Depends on mpq_pkg, mpq_cell and assert_macros.svh.
module min_priority_queue_sorted
  import mpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] dequeued_key, [36:32] entry_count, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  key_t             out_key_r, out_key_nxt;
  status_t          out_stat_r, out_stat_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  logic       in_fire;
  logic       is_enq, is_deq, full, empty;
  cell_ctl_t  ctl;
  cell_link_t link [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_enq    = (func_t'(in_tuser) == FUNC_ENQ);
  assign is_deq    = (func_t'(in_tuser) == FUNC_DEQ);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  assign ctl.enq = in_fire && is_enq && !full;
  assign ctl.deq = in_fire && is_deq && !empty;
  assign ctl.key = key_t'(in_tdata);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t left_in;
    key_t       right_in;
    if (i == 0) begin : g_head
      assign left_in = '{gt: 1'b0, key: '0};
    end else begin : g_body
      assign left_in = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in = link[i].key;
    end else begin : g_mid
      assign right_in = link[i+1].key;
    end
    mpq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (count_r > CNT_W'(i)),
      .at_tail    (count_r == CNT_W'(i)),
      .from_left  (left_in),
      .from_right (right_in),
      .to_right   (link[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_cnt_nxt   = count_nxt;
      out_key_nxt   = '0;
      out_stat_nxt  = STAT_OK;
      if (is_enq && full) begin
        out_stat_nxt = STAT_FULL;
      end else if (is_deq && empty) begin
        out_stat_nxt = STAT_EMPTY;
      end else if (is_deq) begin
        out_key_nxt = link[0].key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_key_r  <= out_key_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign cnt_ext    = {{CNT_OUT_W{1'b0}}, out_cnt_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, cnt_ext[CNT_OUT_W-1:0], out_key_r};
  assign out_tuser  = out_stat_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "occupancy above DEPTH")
  `ASSERT_NEXT(a_full_drop, in_fire && is_enq && full, out_stat_r == STAT_FULL && $stable(count_r), "enqueue on full queue not dropped")
  `ASSERT_NEXT(a_empty_deq, in_fire && is_deq && empty, out_stat_r == STAT_EMPTY && out_key_r == '0, "dequeue on empty queue not flagged")
  `ASSERT_NEXT(a_deq_count, in_fire && is_deq && !empty, count_r == CNT_W'($past(count_r) - 1'b1), "dequeue did not drop occupancy by one")

endmodule
